// File: rtl/core/rfs_pkg.sv
`timescale 1ns / 1ps

package rfs_pkg;

    localparam logic [7:0]  PREAMBLE    = 8'hD3;
    localparam logic [23:0] CRC_POLY    = 24'h864CFB;
    localparam int          BYTE_W      = 8;
    localparam int          IDX_W       = 11;
    localparam int          LEN_W       = 10;
    localparam int          CRC_W       = 24;
    localparam int          TYPE_W      = 12;
    // header bytes (3) ahead of the payload, parity bytes (3) after it
    localparam logic [IDX_W-1:0] HDR_BYTES  = 11'd3;
    localparam logic [IDX_W-1:0] LAST_EXTRA = 11'd5;
    localparam logic [IDX_W-1:0] IDX_LEN_HI = 11'd1;
    localparam logic [IDX_W-1:0] IDX_LEN_LO = 11'd2;
    localparam logic [IDX_W-1:0] IDX_TYPE_HI = 11'd3;
    localparam logic [IDX_W-1:0] IDX_TYPE_LO = 11'd4;
    localparam logic [LEN_W-1:0] MIN_TYPE_LEN = 10'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic [IDX_W-1:0]  byte_index;
        logic              frame_end;
        logic              crc_ok;
        logic [LEN_W-1:0]  payload_length;
        logic [TYPE_W-1:0] message_type;
    } rfs_result_t;

endpackage

// File: rtl/core/rfs_in_stage.sv
`timescale 1ns / 1ps

module rfs_in_stage
    import rfs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    output logic              in_valid,
    output logic [BYTE_W-1:0] in_byte,
    input  logic              in_take
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign s_ready  = !valid_reg || in_take;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (in_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

endmodule

// File: rtl/core/rfs_crc24q.sv
`timescale 1ns / 1ps

module rfs_crc24q
    import rfs_pkg::*;
(
    input  logic [CRC_W-1:0]  crc_in,
    input  logic [BYTE_W-1:0] data_in,
    output logic [CRC_W-1:0]  crc_out
);

    logic [CRC_W-1:0] c;
    logic             msb;

    // MSB-first, one bit per step, eight steps per byte
    always_comb begin
        c = crc_in ^ {data_in, 16'h0000};
        msb = 1'b0;
        for (int k = 0; k < BYTE_W; k++) begin
            msb = c[CRC_W-1];
            c = {c[CRC_W-2:0], 1'b0};
            if (msb) begin
                c = c ^ CRC_POLY;
            end
        end
        crc_out = c;
    end

endmodule

// File: rtl/core/rfs_framer.sv
`timescale 1ns / 1ps

module rfs_framer
    import rfs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              in_take,
    output logic              out_valid,
    input  logic              out_ready,
    output rfs_result_t       out_result
);

    logic [IDX_W-1:0]  pos_reg,  pos_next;
    logic [LEN_W-1:0]  len_reg,  len_next;
    logic [CRC_W-1:0]  crc_reg,  crc_next;
    logic [CRC_W-1:0]  par_reg,  par_next;
    logic [TYPE_W-1:0] type_reg, type_next;
    logic              out_valid_reg, out_valid_next;
    rfs_result_t       result_reg, result_next;

    logic              hunting;
    logic              drop;
    logic              load;
    logic              in_crc;
    logic              last;
    logic [LEN_W-1:0]  len_base;
    logic [CRC_W-1:0]  crc_base;
    logic [CRC_W-1:0]  par_base;
    logic [TYPE_W-1:0] type_base;
    logic [CRC_W-1:0]  crc_upd;

    rfs_crc24q u_crc (
        .crc_in  (crc_base),
        .data_in (in_byte),
        .crc_out (crc_upd)
    );

    assign hunting = (pos_reg == '0);
    assign drop    = hunting && (in_byte != PREAMBLE);
    assign in_take = in_valid && (!out_valid_reg || out_ready);
    assign load    = in_take && !drop;

    always_comb begin
        // a preamble starts from a clean frame context
        len_base  = hunting ? '0 : len_reg;
        crc_base  = hunting ? '0 : crc_reg;
        par_base  = hunting ? '0 : par_reg;
        type_base = hunting ? '0 : type_reg;

        len_next = len_base;
        if (pos_reg == IDX_LEN_HI) begin
            len_next = {in_byte[1:0], 8'h00};
        end else if (pos_reg == IDX_LEN_LO) begin
            len_next = {len_base[LEN_W-1:LEN_W-2], in_byte};
        end

        type_next = type_base;
        if (pos_reg == IDX_TYPE_HI) begin
            type_next = {in_byte, 4'h0};
        end else if (pos_reg == IDX_TYPE_LO) begin
            type_next = {type_base[TYPE_W-1:4], in_byte[7:4]};
        end

        in_crc   = pos_reg < ({1'b0, len_next} + HDR_BYTES);
        crc_next = in_crc ? crc_upd : crc_base;
        par_next = in_crc ? par_base : {par_base[CRC_W-BYTE_W-1:0], in_byte};

        last     = (pos_reg >= IDX_LEN_LO) && (pos_reg == ({1'b0, len_next} + LAST_EXTRA));
        pos_next = last ? '0 : pos_reg + 1'b1;

        result_next.frame_byte     = in_byte;
        result_next.byte_index     = pos_reg;
        result_next.frame_end      = last;
        result_next.crc_ok         = last && (crc_next == par_next);
        result_next.payload_length = (pos_reg >= IDX_LEN_LO) ? len_next : '0;
        result_next.message_type   = (last && (len_next >= MIN_TYPE_LEN)) ? type_next : '0;

        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            len_reg       <= '0;
            crc_reg       <= '0;
            par_reg       <= '0;
            type_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (load) begin
                pos_reg  <= pos_next;
                len_reg  <= len_next;
                crc_reg  <= crc_next;
                par_reg  <= par_next;
                type_reg <= type_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

`ifndef ASSERT_OFF
    a_end_index: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && result_reg.frame_end |->
        result_reg.byte_index == ({1'b0, result_reg.payload_length} + LAST_EXTRA))
        else $error("frame end at wrong index");

    a_end_rehunt: assert property (@(posedge aclk) disable iff (!aresetn)
        load && last |=> pos_reg == '0)
        else $error("framer did not return to hunting after frame end");

    a_ok_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (result_reg.crc_ok || result_reg.message_type != '0) |->
        result_reg.frame_end)
        else $error("end-of-frame fields set mid-frame");

    a_drop_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take && drop |=> $stable(pos_reg))
        else $error("dropped byte changed frame position");
`endif

endmodule

// File: rtl/core/rtcm3_frame_sync_crc24q_top.sv
`timescale 1ns / 1ps

// RTCM 3 frame synchronizer with CRC-24Q check.
// Input channel (s_valid/s_ready/s_rx_byte) takes one received byte per transfer.
// While hunting, every byte other than the 0xD3 preamble is dropped with no result.
// From the preamble on, each byte of the frame (header, payload, three parity
// bytes) yields one result transfer on the m_ channel with its index in the frame.
// The last parity byte carries m_frame_end, m_crc_ok (CRC-24Q over header and
// payload against the big-endian parity) and the 12-bit message type, or zero
// for a payload under two bytes; a failed frame is still passed out, flagged by
// m_crc_ok low. Each accepted byte passes the input register, then the result
// register, before it shows on m_*. Throughput: one byte per cycle while m_ready
// is high, set by the byte-wide CRC update in the framing stage.
// Reset (aresetn low, synchronous) empties both registers and puts the
// framer in hunting state.
// When the receiver stalls, the result register holds its transfer, the input
// register fills, and s_ready drops; no byte is lost.
module rtcm3_frame_sync_crc24q_top
    import rfs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_frame_byte,
    output logic [IDX_W-1:0]  m_byte_index,
    output logic              m_frame_end,
    output logic              m_crc_ok,
    output logic [LEN_W-1:0]  m_payload_length,
    output logic [TYPE_W-1:0] m_message_type
);

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              in_take;
    rfs_result_t       result;

    rfs_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .in_take   (in_take)
    );

    rfs_framer u_framer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_valid),
        .in_byte    (in_byte),
        .in_take    (in_take),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (result)
    );

    assign m_frame_byte     = result.frame_byte;
    assign m_byte_index     = result.byte_index;
    assign m_frame_end      = result.frame_end;
    assign m_crc_ok         = result.crc_ok;
    assign m_payload_length = result.payload_length;
    assign m_message_type   = result.message_type;

endmodule
